>>> src/chord_identifier_assert.svh
// Assertion macros used by the checker file of the chord identifier.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CHORD_IDENTIFIER_ASSERT_SVH
`define CHORD_IDENTIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHID_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHID_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/chid_pkg.sv
package chid_pkg;

	localparam int PC_COUNT = 12;
	localparam int TEMPLATE_COUNT = 13;

	// Reciprocal of twelve for seven-bit values: floor(n / 12) == (n * 43) >> 9.
	localparam int MOD12_RECIP = 43;
	localparam int MOD12_SHIFT = 9;

	localparam logic [6:0] LOWEST_RESET = 7'd127;

	localparam logic [3:0] INTERVAL_FIFTH = 4'd7;
	localparam logic [3:0] INTERVAL_FOURTH = 4'd5;

	localparam logic [3:0] COUNT_SINGLE = 4'd1;
	localparam logic [3:0] COUNT_DYAD = 4'd2;

	localparam logic [4:0] KIND_NONE = 5'd0;
	localparam logic [4:0] KIND_SINGLE = 5'd1;
	localparam logic [4:0] KIND_POWER = 5'd2;
	localparam logic [4:0] KIND_DYAD = 5'd3;
	localparam logic [4:0] KIND_FIRST_TEMPLATE = 5'd4;
	localparam logic [4:0] KIND_POLY = 5'd17;

	// Interval sets, bit i set means i semitones above the root.
	localparam logic [PC_COUNT-1:0] TEMPLATES [TEMPLATE_COUNT] = '{
		12'h091, // major
		12'h089, // minor
		12'h049, // diminished
		12'h111, // augmented
		12'h085, // sus2
		12'h0A1, // sus4
		12'h891, // major seventh
		12'h491, // dominant seventh
		12'h489, // minor seventh
		12'h449, // half-diminished
		12'h249, // diminished seventh
		12'h095, // add9
		12'h0B1  // add11
	};

	// One finished chord waiting to be classified.
	typedef struct packed {
		logic [PC_COUNT-1:0] mask;
		logic [6:0]          lowest;
	} chid_job_t;

	typedef struct packed {
		logic      push;
		chid_job_t job;
	} chid_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} chid_q_status_t;

	function automatic logic [3:0] mod12(input logic [6:0] n);
		logic [12:0] prod;
		logic [6:0]  quo;
		logic [6:0]  rem;
		prod = 13'(n) * 13'(MOD12_RECIP);
		quo  = 7'(prod >> MOD12_SHIFT);
		rem  = n - 7'(quo * 7'(PC_COUNT));
		return rem[3:0];
	endfunction

	function automatic logic [PC_COUNT-1:0] rot_down(input logic [PC_COUNT-1:0] m,
			input logic [3:0] r);
		logic [2*PC_COUNT-1:0] d;
		d = {m, m} >> r;
		return d[PC_COUNT-1:0];
	endfunction

endpackage

>>> src/chid_front.sv
module chid_front
	import chid_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [6:0]     note,
	input  logic           note_valid,
	input  logic           last,
	input  logic           in_valid,
	output logic           in_stall,
	input  chid_q_status_t q_status,
	output chid_push_t     q_push
);

	logic [PC_COUNT-1:0] mask_q;
	logic [6:0]          lowest_q;
	logic [PC_COUNT-1:0] mask_next;
	logic [6:0]          lowest_next;
	logic                accept;

	// Only a full queue holds the front back.
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		mask_next   = mask_q;
		lowest_next = lowest_q;
		if (note_valid) begin
			mask_next = mask_q | (PC_COUNT'(1) << mod12(note));
			if (note < lowest_q) begin
				lowest_next = note;
			end
		end
	end

	assign q_push.push       = accept && last;
	assign q_push.job.mask   = mask_next;
	assign q_push.job.lowest = lowest_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			lowest_q <= LOWEST_RESET;
		end else if (accept) begin
			if (last) begin
				mask_q   <= '0;
				lowest_q <= LOWEST_RESET;
			end else begin
				mask_q   <= mask_next;
				lowest_q <= lowest_next;
			end
		end
	end

endmodule

>>> src/chid_queue.sv
module chid_queue
	import chid_pkg::*;
#(
	parameter int DEPTH = 2
)
(
	input  logic           clk,
	input  logic           arst_n,
	input  chid_push_t     q_push,
	input  logic           pop,
	output chid_job_t      head,
	output chid_q_status_t q_status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	chid_job_t          slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_push;
	logic               do_pop;

	assign q_status.full  = (fill_q == CNT_W'(DEPTH));
	assign q_status.empty = (fill_q == '0);
	assign do_push = q_push.push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= q_push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> src/chid_back.sv
module chid_back
	import chid_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  chid_job_t      head,
	input  chid_q_status_t q_status,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [4:0]     chord_kind,
	output logic [3:0]     root_class,
	output logic [3:0]     second_class,
	output logic [3:0]     class_count
);

	logic       out_valid_q;
	logic [4:0] kind_q;
	logic [3:0] root_q;
	logic [3:0] second_q;
	logic [3:0] count_q;

	logic [4:0] kind_c;
	logic [3:0] root_c;
	logic [3:0] second_c;
	logic [3:0] count_c;
	logic [3:0] lo_c;
	logic [3:0] hi_c;
	logic [3:0] gap_c;
	logic       lo_seen;
	logic       found;
	logic [PC_COUNT-1:0] rot [PC_COUNT];

	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	always_comb begin
		count_c = '0;
		lo_c    = '0;
		hi_c    = '0;
		lo_seen = 1'b0;
		for (int i = 0; i < PC_COUNT; i++) begin
			count_c = count_c + 4'(head.mask[i]);
			if (head.mask[i]) begin
				hi_c = 4'(i);
				if (!lo_seen) begin
					lo_c    = 4'(i);
					lo_seen = 1'b1;
				end
			end
		end
		gap_c = hi_c - lo_c;
	end

	always_comb begin
		for (int r = 0; r < PC_COUNT; r++) begin
			rot[r] = rot_down(head.mask, 4'(r));
		end
	end

	always_comb begin
		kind_c   = KIND_NONE;
		root_c   = '0;
		second_c = '0;
		found    = 1'b0;
		priority if (count_c == '0) begin
			kind_c = KIND_NONE;
		end else if (count_c == COUNT_SINGLE) begin
			kind_c = KIND_SINGLE;
			root_c = hi_c;
		end else if (count_c == COUNT_DYAD) begin
			priority if (gap_c == INTERVAL_FIFTH) begin
				kind_c = KIND_POWER;
				root_c = lo_c;
			end else if (gap_c == INTERVAL_FOURTH) begin
				kind_c = KIND_POWER;
				root_c = hi_c;
			end else begin
				kind_c   = KIND_DYAD;
				root_c   = lo_c;
				second_c = hi_c;
			end
		end else begin
			// First match wins: lowest root, then template order.
			for (int r = 0; r < PC_COUNT; r++) begin
				for (int t = 0; t < TEMPLATE_COUNT; t++) begin
					if (!found && rot[r] == TEMPLATES[t]) begin
						found  = 1'b1;
						kind_c = KIND_FIRST_TEMPLATE + 5'(t);
						root_c = 4'(r);
					end
				end
			end
			if (!found) begin
				kind_c = KIND_POLY;
				root_c = mod12(head.lowest);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= kind_c;
			root_q   <= root_c;
			second_q <= second_c;
			count_q  <= count_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign chord_kind   = kind_q;
	assign root_class   = root_q;
	assign second_class = second_q;
	assign class_count  = count_q;

endmodule

>>> src/chord_identifier.sv
// Path: the edge that takes the transaction flagged last pushes the finished chord into
// the queue; the back pops it from there and registers the result with out_valid.
// Throughput: one note transaction per cycle while in_stall is low and one chord result
// per cycle while out_stall is low; the queue between front and back absorbs output stalls.
// Reset: arst_n is asynchronous, active low; it empties the queue, drops out_valid,
// and returns the pitch-class set to empty and the lowest note to 127.
//
// Structure. The front end folds each accepted note into a 12-bit pitch-class set and
// keeps the lowest valid note seen. When the transaction flagged last arrives, the note
// it carries is folded in first and the finished chord (set plus lowest note) is pushed
// into a short queue; the front then starts a fresh chord in the very next cycle.
//
// The back end pops one chord at a time and classifies it combinationally: it counts
// the classes, treats single notes and dyads directly, and otherwise tries all twelve
// rotations of the set against the thirteen chord shapes, the lowest root winning and,
// for one root, the earlier shape. A chord matching no shape is reported as poly, rooted
// at the pitch class of its lowest note. The result sits in an output register which
// holds steady while out_valid and out_stall are both high.
//
// The front stalls its input only when the queue is full, which takes QUEUE_DEPTH finished
// chords waiting in the queue while one more is held in the output register.
module chord_identifier
	import chid_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [6:0] note,
	input  logic       note_valid,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] chord_kind,
	output logic [3:0] root_class,
	output logic [3:0] second_class,
	output logic [3:0] class_count
);

	chid_push_t     q_push;
	chid_q_status_t q_status;
	chid_job_t      head;
	logic           pop;

	chid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.note       (note),
		.note_valid (note_valid),
		.last       (last),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_status   (q_status),
		.q_push     (q_push)
	);

	// Chords waiting between the accumulator and the classifier.
	chid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	chid_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chord_kind   (chord_kind),
		.root_class   (root_class),
		.second_class (second_class),
		.class_count  (class_count)
	);

endmodule

>>> src/chid_checker.sv
`include "chord_identifier_assert.svh"

module chid_checker
	import chid_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] chord_kind,
	input logic [3:0] root_class,
	input logic [3:0] second_class,
	input logic [3:0] class_count
);

	// A held result transaction stays put.
	`CHID_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(chord_kind) && $stable(root_class) && $stable(second_class) && $stable(class_count), "result changed while stalled")

	`CHID_ASSERT_IMP(a_kind_range, out_valid, chord_kind <= KIND_POLY, "chord kind out of range")

	// An empty chord and kind none go together, with the root class zero as well.
	`CHID_ASSERT_IMP(a_empty, out_valid && (class_count == '0 || chord_kind == KIND_NONE), class_count == '0 && chord_kind == KIND_NONE && root_class == '0, "empty chord mismatch")

	`CHID_ASSERT_IMP(a_second, out_valid && second_class != '0, chord_kind == KIND_DYAD, "second class outside a plain dyad")

	`CHID_ASSERT_IMP(a_small_count, out_valid && (chord_kind == KIND_SINGLE || chord_kind == KIND_POWER || chord_kind == KIND_DYAD), (chord_kind == KIND_SINGLE) ? (class_count == COUNT_SINGLE) : (class_count == COUNT_DYAD), "class count disagrees with kind")

endmodule

bind chord_identifier chid_checker u_chid_checker (.*);

>>> test/tb_chord_identifier.sv
`timescale 1ns / 100ps

module tb_chord_identifier;
	import chid_pkg::*;

	// One classified chord as it leaves the block.
	typedef struct packed {
		logic [4:0] kind;
		logic [3:0] root;
		logic [3:0] second;
		logic [3:0] count;
	} chord_result_t;

	// One note transaction as it is presented to the block.
	typedef struct packed {
		logic [6:0] pitch;
		logic       counts;
	} held_note_t;

	// The shapes of chord which the random part builds.
	typedef enum int {
		FORM_EMPTY,
		FORM_SINGLE,
		FORM_POWER,
		FORM_DYAD,
		FORM_SHAPE,
		FORM_POLY,
		FORM_NOISE
	} chord_form_t;

	localparam int SHAPE_COUNT = 13;
	localparam int RANDOM_NOTES = 1350;
	localparam int QUIET_TAIL = 200;
	localparam int SETTLE_CYCLES = 8;

	// Interval sets in the priority order of the kinds that follow the dyad: bit i set
	// means a class i semitones above the root.
	localparam logic [11:0] CHORD_SHAPES [SHAPE_COUNT] = '{
		12'h091, 12'h089, 12'h049, 12'h111, 12'h085, 12'h0A1, 12'h891,
		12'h491, 12'h489, 12'h449, 12'h249, 12'h095, 12'h0B1
	};

	// The scoreboard keeps its own copy of the pitch-class set and of the lowest note,
	// classifies every finished chord and holds the outcomes until the block reports them.
	class chord_scoreboard;
		logic [11:0]   held_classes;
		logic [6:0]    lowest_held;
		chord_result_t expected_chords[$];
		int unsigned   failures;

		function new();
			held_classes = '0;
			lowest_held = LOWEST_RESET;
			failures = 0;
		endfunction

		function chord_result_t classify(logic [11:0] classes, logic [6:0] lowest);
			chord_result_t res;
			logic [23:0]   doubled;
			logic [11:0]   turned;
			int            lo;
			int            hi;
			bit            found;
			res = '{KIND_NONE, 4'd0, 4'd0, 4'd0};
			res.count = 4'($countones(classes));
			lo = -1;
			hi = -1;
			found = 0;
			for (int i = 0; i < 12; i++) begin
				if (classes[i]) begin
					if (lo < 0)
						lo = i;
					else
						hi = i;
				end
			end
			if (res.count == 4'd1) begin
				res.kind = KIND_SINGLE;
				res.root = 4'(lo);
			end else if (res.count == 4'd2) begin
				if (hi - lo == 7) begin
					res.kind = KIND_POWER;
					res.root = 4'(lo);
				end else if (hi - lo == 5) begin
					res.kind = KIND_POWER;
					res.root = 4'(hi);
				end else begin
					res.kind = KIND_DYAD;
					res.root = 4'(lo);
					res.second = 4'(hi);
				end
			end else if (res.count >= 4'd3) begin
				doubled = {classes, classes};
				for (int r = 0; r < 12 && !found; r++) begin
					turned = doubled[r +: 12];
					for (int t = 0; t < SHAPE_COUNT && !found; t++) begin
						if (turned == CHORD_SHAPES[t]) begin
							res.kind = KIND_FIRST_TEMPLATE + 5'(t);
							res.root = 4'(r);
							found = 1;
						end
					end
				end
				if (!found) begin
					res.kind = KIND_POLY;
					res.root = 4'(lowest % 7'd12);
				end
			end
			return res;
		endfunction

		function void note_taken(logic [6:0] pitch, logic counts, logic fin);
			if (counts) begin
				held_classes[pitch % 7'd12] = 1'b1;
				if (pitch < lowest_held)
					lowest_held = pitch;
			end
			if (fin) begin
				expected_chords.insert(expected_chords.size(),
					classify(held_classes, lowest_held));
				held_classes = '0;
				lowest_held = LOWEST_RESET;
			end
		endfunction

		function void compare_field(string what, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
				failures++;
			end
		endfunction

		function void check_chord(chord_result_t got);
			chord_result_t want;
			if (expected_chords.size() == 0) begin
				$display("%0t: chord result with none expected, expected nothing, got kind %0d",
					$time, got.kind);
				failures++;
				return;
			end
			want = expected_chords.pop_front();
			compare_field("chord_kind", want.kind, got.kind);
			compare_field("root_class", want.root, got.root);
			compare_field("second_class", want.second, got.second);
			compare_field("class_count", want.count, got.count);
		endfunction

		function int pending();
			return expected_chords.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [6:0] note;
	logic       note_valid;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic [4:0] chord_kind;
	logic [3:0] root_class;
	logic [3:0] second_class;
	logic [3:0] class_count;

	// When this is set, both sides of the block idle in random bursts; it is cleared for
	// whole stretches of chords so that back-to-back traffic is seen as well.
	bit idling_on;
	int notes_driven;

	chord_scoreboard sb = new();

	chord_identifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.note         (note),
		.note_valid   (note_valid),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chord_kind   (chord_kind),
		.root_class   (root_class),
		.second_class (second_class),
		.class_count  (class_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Presents one note transaction. It is entered just after a falling edge, changes the
	// inputs there, and returns just after the falling edge that follows acceptance, so
	// that the next call may drive the inputs again without a second update in one step.
	task automatic send_note(input logic [6:0] pitch, input logic counts, input logic fin);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		note <= pitch;
		note_valid <= counts;
		last <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_taken(pitch, counts, fin);
		if (counts || fin)
			notes_driven++;
		@(negedge clk);
	endtask

	// A note of the given pitch class in a random octave that still fits in seven bits.
	function automatic logic [6:0] voiced(int pc);
		return 7'(pc + 12 * $urandom_range(0, (127 - pc) / 12));
	endfunction

	// Plays one chord built from a set of pitch classes. Each class is sounded once or
	// twice in random octaves, skipped notes are sometimes mixed in, and the order is
	// shuffled. Now and then the chord is closed by a skipped transaction carrying last,
	// which must still trigger the classification.
	task automatic play_chord(input logic [11:0] classes);
		held_note_t chord_notes[$];
		held_note_t swap;
		held_note_t one;
		int         j;
		for (int pc = 0; pc < 12; pc++) begin
			if (classes[pc]) begin
				repeat ($urandom_range(1, 2)) begin
					one = '{voiced(pc), 1'b1};
					chord_notes.insert(chord_notes.size(), one);
				end
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				one = '{7'($urandom_range(0, 127)), 1'b0};
				chord_notes.insert(chord_notes.size(), one);
			end
		end
		for (int i = chord_notes.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = chord_notes[i];
			chord_notes[i] = chord_notes[j];
			chord_notes[j] = swap;
		end
		if (chord_notes.size() == 0 || $urandom_range(0, 5) == 0) begin
			one = '{7'($urandom_range(0, 127)), 1'b0};
			chord_notes.insert(chord_notes.size(), one);
		end
		for (int k = 0; k < chord_notes.size(); k++)
			send_note(chord_notes[k].pitch, chord_notes[k].counts, k == chord_notes.size() - 1);
	endtask

	// Draws one random chord. Most of them are well-formed shapes on random roots so
	// that every kind is reached often; a share are arbitrary sets and plain noise.
	task automatic play_random_chord();
		chord_form_t form;
		logic [11:0] classes;
		int          pick;
		int          pc;
		int          shape;
		int          root;
		int          length;
		pick = $urandom_range(0, 99);
		classes = '0;
		if (pick < 4)
			form = FORM_EMPTY;
		else if (pick < 12)
			form = FORM_SINGLE;
		else if (pick < 22)
			form = FORM_POWER;
		else if (pick < 32)
			form = FORM_DYAD;
		else if (pick < 80)
			form = FORM_SHAPE;
		else if (pick < 92)
			form = FORM_POLY;
		else
			form = FORM_NOISE;
		case (form)
			FORM_EMPTY: begin
				classes = '0;
			end
			FORM_SINGLE: begin
				classes[$urandom_range(0, 11)] = 1'b1;
			end
			FORM_POWER: begin
				// A fifth above any class; where it wraps past B it becomes a fourth.
				pc = $urandom_range(0, 11);
				classes[pc] = 1'b1;
				classes[(pc + 7) % 12] = 1'b1;
			end
			FORM_DYAD: begin
				pc = $urandom_range(0, 11);
				classes[pc] = 1'b1;
				classes[(pc + $urandom_range(1, 11)) % 12] = 1'b1;
			end
			FORM_SHAPE: begin
				shape = $urandom_range(0, SHAPE_COUNT - 1);
				root = $urandom_range(0, 11);
				for (int i = 0; i < 12; i++) begin
					if (CHORD_SHAPES[shape][i])
						classes[(i + root) % 12] = 1'b1;
				end
			end
			FORM_POLY: begin
				do
					classes = 12'($urandom());
				while ($countones(classes) < 3);
			end
			default: begin
				length = $urandom_range(1, 6);
				for (int k = 0; k < length; k++)
					send_note(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
						k == length - 1);
			end
		endcase
		if (form != FORM_NOISE)
			play_chord(classes);
	endtask

	// The result side holds off in bursts of its own while idling is enabled.
	initial begin
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every result taken by the receiving side goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_chord('{chord_kind, root_class, second_class, class_count});
	end

	initial begin
		int target;
		int chord_no;
		arst_n = 1'b0;
		in_valid = 1'b0;
		note = '0;
		note_valid = 1'b0;
		last = 1'b0;
		out_stall = 1'b0;
		idling_on = 0;
		notes_driven = 0;
		chord_no = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idling_on = 1;

		// An empty chord: only a skipped transaction, flagged last.
		send_note(7'd0, 1'b0, 1'b1);
		// Single notes at both ends of the note range.
		send_note(7'd0, 1'b1, 1'b1);
		send_note(7'd127, 1'b1, 1'b1);
		// A power chord as a fifth, rooted at its lower class.
		send_note(7'd48, 1'b1, 1'b0);
		send_note(7'd55, 1'b1, 1'b1);
		// A power chord as a fourth, D below G, rooted at the upper class.
		send_note(7'd62, 1'b1, 1'b0);
		send_note(7'd67, 1'b1, 1'b1);
		// A plain major third.
		send_note(7'd60, 1'b1, 1'b0);
		send_note(7'd64, 1'b1, 1'b1);
		// Skipped notes leave the set and the lowest note alone, even when the skipped
		// one is the lowest pitch or closes the chord.
		send_note(7'd64, 1'b1, 1'b0);
		send_note(7'd5, 1'b0, 1'b0);
		send_note(7'd67, 1'b1, 1'b0);
		send_note(7'd127, 1'b0, 1'b1);
		// A major chord on A, whose classes wrap past B.
		send_note(7'd57, 1'b1, 1'b0);
		send_note(7'd61, 1'b1, 1'b0);
		send_note(7'd64, 1'b1, 1'b1);
		// A diminished seventh fits four roots; the lowest root must win.
		send_note(7'd63, 1'b1, 1'b0);
		send_note(7'd66, 1'b1, 1'b0);
		send_note(7'd69, 1'b1, 1'b0);
		send_note(7'd72, 1'b1, 1'b1);
		// A cluster that fits no shape, rooted at the class of its lowest note.
		send_note(7'd50, 1'b1, 1'b0);
		send_note(7'd37, 1'b1, 1'b0);
		send_note(7'd72, 1'b1, 1'b1);
		// An add11 chord, which also holds a complete major triad.
		send_note(7'd60, 1'b1, 1'b0);
		send_note(7'd65, 1'b1, 1'b0);
		send_note(7'd67, 1'b1, 1'b0);
		send_note(7'd64, 1'b1, 1'b1);

		// Random chords, in stretches with and without idling, and a quiet tail.
		target = notes_driven + RANDOM_NOTES;
		while (notes_driven < target) begin
			if (notes_driven >= target - QUIET_TAIL)
				idling_on = 0;
			else if (chord_no % 25 == 0)
				idling_on = ($urandom_range(0, 3) != 0);
			play_random_chord();
			chord_no++;
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("** chord_identifier: PASSED **");
		end else begin
			$display("** chord_identifier: FAILED **");
		end
		$finish;
	end

	// A hung handshake ends the run here; a correct run needs a small fraction of this.
	initial begin
		#5_000_000;
		$display("** chord_identifier: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/chid_pkg.sv
src/chid_front.sv
src/chid_queue.sv
src/chid_back.sv
src/chord_identifier.sv
src/chid_checker.sv
test/tb_chord_identifier.sv
